FILE: design/tktc_pkg.sv
// Shared constants, types and helpers for the tick timekeeper.
`default_nettype none

package tktc_pkg;

  // Default tick rate, in ticks per second.
  localparam int unsigned TICKS_PER_SECOND_DEF = 1600;

  // Fixed field widths of the request and result.
  localparam int unsigned SUB_SECOND_W = 11;
  localparam int unsigned SEC_W        = 6;
  localparam int unsigned MIN_W        = 6;
  localparam int unsigned HOUR_W       = 32;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned UPSEC_W      = 32;
  localparam int unsigned LOAD_W       = 8;

  // Wall-clock limits.
  localparam logic [SEC_W-1:0] LAST_SECOND = SEC_W'(59);
  localparam logic [MIN_W-1:0] LAST_MINUTE = MIN_W'(59);

  // Request command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Events raised by the wall-clock cascade.
  typedef struct packed {
    logic second;
    logic ten_second;
  } wall_event_t;

  // True when a seconds value is a multiple of ten below 60.
  function automatic logic is_ten_multiple(input logic [SEC_W-1:0] value);
    return (value == SEC_W'(0))  || (value == SEC_W'(10)) ||
           (value == SEC_W'(20)) || (value == SEC_W'(30)) ||
           (value == SEC_W'(40)) || (value == SEC_W'(50));
  endfunction

endpackage

`default_nettype wire

FILE: design/tktc_wall_clock.sv
// Wall-clock cascade: sub-second, seconds, minutes and hours.
`default_nettype none

module tktc_wall_clock #(
  parameter int unsigned TICKS_PER_SECOND = tktc_pkg::TICKS_PER_SECOND_DEF,
  localparam int unsigned SW = $clog2(TICKS_PER_SECOND)
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             tick,
  output logic [SW-1:0]                   sub_second_next,
  output logic [tktc_pkg::SEC_W-1:0]      seconds_next,
  output logic [tktc_pkg::MIN_W-1:0]      minutes_next,
  output logic [tktc_pkg::HOUR_W-1:0]     hours_next,
  output tktc_pkg::wall_event_t           events
);

  localparam logic [SW-1:0] LAST_SUB = SW'(TICKS_PER_SECOND - 1);

  logic [SW-1:0]                   sub_second_count;
  logic [tktc_pkg::SEC_W-1:0]      second_count;
  logic [tktc_pkg::MIN_W-1:0]      minute_count;
  logic [tktc_pkg::HOUR_W-1:0]     hour_count;

  logic sub_wrap;
  logic sec_wrap;
  logic min_wrap;

  // Carry chain of the cascade; each stage advances on the wrap of the one below.
  assign sub_wrap = tick && (sub_second_count == LAST_SUB);
  assign sec_wrap = sub_wrap && (second_count == tktc_pkg::LAST_SECOND);
  assign min_wrap = sec_wrap && (minute_count == tktc_pkg::LAST_MINUTE);

  always_comb begin
    sub_second_next = sub_second_count;
    seconds_next    = second_count;
    minutes_next    = minute_count;
    hours_next      = hour_count;
    if (tick) begin
      sub_second_next = sub_wrap ? '0 : sub_second_count + SW'(1);
    end
    if (sub_wrap) begin
      seconds_next = sec_wrap ? '0 : second_count + tktc_pkg::SEC_W'(1);
    end
    if (sec_wrap) begin
      minutes_next = min_wrap ? '0 : minute_count + tktc_pkg::MIN_W'(1);
    end
    if (min_wrap) begin
      hours_next = hour_count + tktc_pkg::HOUR_W'(1);
    end
  end

  // Events of this tick.
  assign events.second     = sub_wrap;
  assign events.ten_second = sub_wrap && tktc_pkg::is_ten_multiple(seconds_next);

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_second_count <= '0;
      second_count     <= '0;
      minute_count     <= '0;
      hour_count       <= '0;
    end else begin
      sub_second_count <= sub_second_next;
      second_count     <= seconds_next;
      minute_count     <= minutes_next;
      hour_count       <= hours_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/tktc_uptime.sv
// Free-running tick count, uptime seconds and the seconds countdown.
`default_nettype none

module tktc_uptime #(
  parameter int unsigned TICKS_PER_SECOND = tktc_pkg::TICKS_PER_SECOND_DEF,
  localparam int unsigned SW = $clog2(TICKS_PER_SECOND)
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              tick,
  input  wire                              load,
  input  wire  [tktc_pkg::LOAD_W-1:0]      load_value,
  output logic [tktc_pkg::TICK_W-1:0]      ticks_next,
  output logic [tktc_pkg::UPSEC_W-1:0]     uptime_seconds_next,
  output logic [tktc_pkg::LOAD_W-1:0]      countdown_next,
  output logic                             timeout
);

  localparam logic [SW-1:0] LAST_PHASE = SW'(TICKS_PER_SECOND - 1);

  logic [tktc_pkg::TICK_W-1:0]   tick_total;
  logic [SW-1:0]                 tick_phase;
  logic [tktc_pkg::UPSEC_W-1:0]  uptime_second_count;
  logic [tktc_pkg::LOAD_W-1:0]   countdown_count;

  logic [SW-1:0] phase_next;
  logic          whole_second;
  logic          counting;

  // Tick count and its phase; the phase restarts at each whole second and when the count wraps.
  always_comb begin
    ticks_next = tick_total;
    phase_next = tick_phase;
    if (tick) begin
      ticks_next = tick_total + tktc_pkg::TICK_W'(1);
      if (ticks_next == '0 || tick_phase == LAST_PHASE) begin
        phase_next = '0;
      end else begin
        phase_next = tick_phase + SW'(1);
      end
    end
  end

  assign whole_second = tick && (phase_next == '0);
  assign counting     = whole_second && (countdown_count != '0);

  // Uptime seconds and the countdown, which steps on the same ticks.
  always_comb begin
    uptime_seconds_next = uptime_second_count;
    countdown_next      = countdown_count;
    if (load) begin
      countdown_next = load_value;
    end else if (counting) begin
      countdown_next = countdown_count - tktc_pkg::LOAD_W'(1);
    end
    if (whole_second) begin
      uptime_seconds_next = uptime_second_count + tktc_pkg::UPSEC_W'(1);
    end
  end

  assign timeout = counting && (countdown_count == tktc_pkg::LOAD_W'(1));

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_total          <= '0;
      tick_phase          <= '0;
      uptime_second_count <= '0;
      countdown_count     <= '0;
    end else begin
      tick_total          <= ticks_next;
      tick_phase          <= phase_next;
      uptime_second_count <= uptime_seconds_next;
      countdown_count     <= countdown_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/tick_timekeeper_with_countdown_unit.sv
// Top level of the tick timekeeper with a seconds countdown.
//
// Input channel (in_valid, in_stall, cmd, timer_load): each request is either
// one timer tick (cmd = 0) or a load of the countdown (cmd = 1).
// Output channel (out_valid, out_stall and the result fields): exactly one
// result per request, in request order, giving the state after the request.
// A request is taken into an input register, runs through one pass of counter
// logic and lands in the output register. One request per cycle is sustained
// while the receiver does not stall; the figure is set by the single counter
// pass between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register holds the next request; in_stall rises only once both are
// full, so no request is lost or repeated.
// Reset (rst, synchronous) clears all counters, the countdown and both
// register valids; the first tick after reset reports a sub-second of one.
// Events: second and ten-second on the wall-clock carries, timeout when the
// countdown reaches zero, key scan on every tick; a load raises none.
`default_nettype none

module tick_timekeeper_with_countdown_unit #(
  parameter int unsigned TICKS_PER_SECOND = tktc_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  cmd,
  input  wire  [tktc_pkg::LOAD_W-1:0]          timer_load,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [tktc_pkg::SUB_SECOND_W-1:0]    sub_second,
  output logic [tktc_pkg::SEC_W-1:0]           seconds,
  output logic [tktc_pkg::MIN_W-1:0]           minutes,
  output logic [tktc_pkg::HOUR_W-1:0]          hours,
  output logic [tktc_pkg::TICK_W-1:0]          uptime_ticks,
  output logic [tktc_pkg::UPSEC_W-1:0]         uptime_seconds,
  output logic [tktc_pkg::LOAD_W-1:0]          countdown_left,
  output logic                                 second_event,
  output logic                                 ten_second_event,
  output logic                                 timeout_event,
  output logic                                 key_scan_event
);

  localparam int unsigned SW = $clog2(TICKS_PER_SECOND);

  // Input register.
  logic                          req_valid;
  logic                          req_cmd;
  logic [tktc_pkg::LOAD_W-1:0]   req_load;

  logic advance;
  logic tick;
  logic load;

  logic [SW-1:0]                            sub_next;
  logic [SW+tktc_pkg::SUB_SECOND_W-1:0]     sub_ext;
  logic [tktc_pkg::SEC_W-1:0]               sec_next;
  logic [tktc_pkg::MIN_W-1:0]               min_next;
  logic [tktc_pkg::HOUR_W-1:0]              hour_next;
  logic [tktc_pkg::TICK_W-1:0]              ticks_next;
  logic [tktc_pkg::UPSEC_W-1:0]             upsec_next;
  logic [tktc_pkg::LOAD_W-1:0]              countdown_next;
  logic                                     timeout;
  tktc_pkg::wall_event_t                    wall_events;

  // The held request moves on whenever the output register is free or drains.
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;
  assign tick     = advance && (req_cmd == tktc_pkg::CMD_TICK);
  assign load     = advance && (req_cmd == tktc_pkg::CMD_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_cmd  <= cmd;
      req_load <= timer_load;
    end
  end

  // Counter logic.
  tktc_wall_clock #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_wall_clock (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .sub_second_next (sub_next),
    .seconds_next    (sec_next),
    .minutes_next    (min_next),
    .hours_next      (hour_next),
    .events          (wall_events)
  );

  tktc_uptime #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_uptime (
    .clk                 (clk),
    .rst                 (rst),
    .tick                (tick),
    .load                (load),
    .load_value          (req_load),
    .ticks_next          (ticks_next),
    .uptime_seconds_next (upsec_next),
    .countdown_next      (countdown_next),
    .timeout             (timeout)
  );

  // The sub-second field carries the low bits of the counter.
  assign sub_ext = {{tktc_pkg::SUB_SECOND_W{1'b0}}, sub_next};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sub_second       <= sub_ext[tktc_pkg::SUB_SECOND_W-1:0];
      seconds          <= sec_next;
      minutes          <= min_next;
      hours            <= hour_next;
      uptime_ticks     <= ticks_next;
      uptime_seconds   <= upsec_next;
      countdown_left   <= countdown_next;
      second_event     <= wall_events.second;
      ten_second_event <= wall_events.ten_second;
      timeout_event    <= timeout;
      key_scan_event   <= tick;
    end
  end

  // A load result carries no events.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_scan_event) |->
      (!second_event && !ten_second_event && !timeout_event))
    else $error("event raised on a load result");

  // A ten-second event only comes with a second boundary.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && ten_second_event) |-> second_event)
    else $error("ten-second event without second event");

  // A timeout leaves the countdown at zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && timeout_event) |-> (countdown_left == '0))
    else $error("timeout with countdown still running");

  // The input side only stalls while the output side is held.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && req_valid))
    else $error("input stalled while output free");

endmodule

`default_nettype wire
